>>> rtl/core/cpra_pkg.sv
// Package for the contiguous page-run allocator.
// Region geometry, command/status codes, FSM states, controller/datapath structs.
// No dependencies.
package cpra_pkg;

    localparam int TABLE_COUNT     = 16;
    localparam int PAGES_PER_TABLE = 1024;
    localparam int TOTAL_PAGES     = TABLE_COUNT * PAGES_PER_TABLE;
    localparam int PAGE_W          = $clog2(TOTAL_PAGES);
    localparam int TABLE_W         = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int SLOT_W          = $clog2(PAGES_PER_TABLE);
    localparam int WORD_W          = 32;
    localparam int WORD_COUNT      = (TOTAL_PAGES + WORD_W - 1) / WORD_W;
    localparam int WIDX_W          = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W           = $clog2(WORD_W);
    localparam int PCNT_W          = PAGE_W + 1;
    localparam int COUNT_W         = 15;
    localparam int FIRST_W         = 14;
    localparam int MADE_W          = 5;
    localparam int STATUS_W        = 2;
    localparam int VERSION_W       = 32;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_CREATE,
        S_MARK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear_step;  // zero one memory word
        logic load;        // capture request, reset cursors
        logic search_step; // examine one page
        logic create_step; // examine one table
        logic mark_step;   // write one page mark
        logic finish;      // latch result
    } ctl_t;

    typedef struct packed {
        logic     clear_end;
        logic     found;
        logic     search_end;
        logic     create_end;
        logic     mark_end;
        logic     trivial;   // zero count or range fault: no work
        cmd_t     cmd;
    } sts_t;

endpackage

>>> rtl/core/cpra_ctrl.sv
// Controller for the page-run allocator: sequences search, table creation and marking.
// Depends on cpra_pkg.
module cpra_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  cpra_pkg::sts_t  sts,
    output cpra_pkg::ctl_t  ctl,
    output logic            busy,
    output logic            strobe
);
    import cpra_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (sts.clear_end) state_next = S_IDLE;
            S_IDLE:
                if (start) state_next = S_SEARCH;
            S_SEARCH:
            begin
                if (sts.trivial)
                    state_next = S_DONE;
                else if (sts.cmd == CMD_FREE)
                    state_next = S_MARK;
                else if (sts.found)
                    state_next = S_CREATE;
                else if (sts.search_end)
                    state_next = S_DONE;
            end
            S_CREATE:
                if (sts.create_end) state_next = S_MARK;
            S_MARK:
                if (sts.mark_end) state_next = S_DONE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        busy = 1'b1;
        strobe = 1'b0;
        case (state_reg)
            S_CLEAR:
                ctl.clear_step = 1'b1;
            S_IDLE:
            begin
                busy = 1'b0;
                ctl.load = start;
            end
            S_SEARCH:
                ctl.search_step = !sts.trivial && sts.cmd == CMD_ALLOC && !sts.found;
            S_CREATE:
                ctl.create_step = 1'b1;
            S_MARK:
                ctl.mark_step = 1'b1;
            S_DONE:
            begin
                ctl.finish = 1'b1;
                strobe = 1'b1;
            end
            default:
                busy = 1'b1;
        endcase
    end

endmodule

>>> rtl/core/cpra_dp.sv
// Datapath for the page-run allocator: page-mark memory, table present bits,
// run counters, version counter and result registers. Depends on cpra_pkg.
module cpra_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cpra_pkg::ctl_t                     ctl,
    input  logic                               command,
    input  logic [cpra_pkg::COUNT_W-1:0]       page_count,
    input  logic [cpra_pkg::FIRST_W-1:0]       first_page_in,
    output cpra_pkg::sts_t                     sts,
    output logic [cpra_pkg::STATUS_W-1:0]      status,
    output logic [cpra_pkg::FIRST_W-1:0]       first_page_out,
    output logic [cpra_pkg::MADE_W-1:0]        tables_created,
    output logic [cpra_pkg::VERSION_W-1:0]     directory_version
);
    import cpra_pkg::*;

    // page marks, one bit per page, packed 32 to a word
    logic [WORD_W-1:0] mem [WORD_COUNT];
    logic [TABLE_COUNT-1:0] present_reg, present_next;
    logic [VERSION_W-1:0] version_reg, version_next;

    cmd_t              cmd_reg;
    logic [PCNT_W-1:0] count_reg;
    logic              trivial_reg;
    logic [PCNT_W-1:0] cur_reg, cur_next;     // current page cursor
    logic [PCNT_W-1:0] start_reg, start_next;
    logic [PCNT_W-1:0] len_reg, len_next;
    logic [PCNT_W-1:0] end_reg;               // last page of run, inclusive
    logic              found_reg;
    logic [TABLE_W:0]  tcur_reg;
    logic [MADE_W-1:0] made_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [FIRST_W-1:0]  first_reg;
    logic [MADE_W-1:0]   tc_reg;
    logic [WIDX_W-1:0]   clr_reg;             // word being zeroed after reset

    // word read is registered: word_reg holds mem at word_addr_reg
    logic [WORD_W-1:0] word_reg;
    logic [WIDX_W-1:0] word_addr_reg;
    logic              word_ok_reg;
    logic [WIDX_W-1:0] cur_widx;
    logic [BIT_W-1:0]  cur_bit;
    logic [TABLE_W-1:0] cur_tab;
    logic              page_free;
    logic              need_read;
    logic [PCNT_W-1:0] cnt_ext;
    logic [PCNT_W-1:0] first_ext;
    logic              range_bad;
    logic [TABLE_W-1:0] tidx;
    logic [PCNT_W-1:0] end_calc;

    function automatic logic [WORD_W-1:0] page_word(
        input logic [WORD_W-1:0] w, input logic [BIT_W-1:0] b, input logic v);
        logic [WORD_W-1:0] r;
        r = w;
        r[b] = v;
        return r;
    endfunction

    assign cur_widx  = cur_reg[BIT_W +: WIDX_W];
    assign cur_bit   = cur_reg[BIT_W-1:0];
    assign cur_tab   = TABLE_W'(cur_reg / PAGES_PER_TABLE);
    assign need_read = !word_ok_reg || word_addr_reg != cur_widx;
    assign page_free = !present_reg[cur_tab] || !word_reg[cur_bit];
    assign cnt_ext   = PCNT_W'(page_count);
    assign first_ext = PCNT_W'(first_page_in);
    assign range_bad = cnt_ext > PCNT_W'(TOTAL_PAGES) - first_ext;
    assign tidx      = tcur_reg[TABLE_W-1:0];
    assign end_calc  = start_reg + count_reg - PCNT_W'(1);

    // search: one page per cycle, pausing for a read when the word changes
    always_comb
    begin
        cur_next   = cur_reg;
        start_next = start_reg;
        len_next   = len_reg;
        if (ctl.load)
        begin
            cur_next   = (command == CMD_FREE) ? first_ext : PCNT_W'(1);
            len_next   = '0;
            start_next = '0;
        end
        else if (ctl.search_step && !need_read)
        begin
            if (page_free)
            begin
                if (len_reg == '0) start_next = cur_reg;
                len_next = len_reg + PCNT_W'(1);
            end
            else
                len_next = '0;
            if (!(page_free && len_reg + PCNT_W'(1) >= count_reg))
                cur_next = cur_reg + PCNT_W'(1);
        end
        else if (ctl.create_step)
            cur_next = start_reg;  // rewind for marking
        else if (ctl.mark_step && !need_read)
            cur_next = cur_reg + PCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            version_reg <= '0;
            word_ok_reg <= 1'b0;
            found_reg   <= 1'b0;
            clr_reg     <= '0;
        end
        else
        begin
            present_reg <= present_next;
            version_reg <= version_next;
            if (ctl.clear_step)
                clr_reg <= clr_reg + WIDX_W'(1);
            if (ctl.load || ctl.create_step)
                word_ok_reg <= 1'b0;   // memory may change under the cache
            else if ((ctl.search_step || ctl.mark_step) && need_read)
                word_ok_reg <= 1'b1;
            if (ctl.load)
                found_reg <= 1'b0;
            else if (ctl.search_step && !need_read && page_free
                     && len_reg + PCNT_W'(1) >= count_reg)
                found_reg <= 1'b1;
        end
    end

    // table creation: one table per cycle over the run's tables
    always_comb
    begin
        present_next = present_reg;
        version_next = version_reg;
        if (ctl.create_step && tcur_reg <= (TABLE_W+1)'(end_calc / PAGES_PER_TABLE)
            && !present_reg[tidx])
        begin
            present_next[tidx] = 1'b1;
            version_next = version_reg + VERSION_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg     <= cmd_t'(command);
            count_reg   <= cnt_ext;
            trivial_reg <= (cnt_ext == '0) || (command == CMD_FREE && range_bad);
            made_reg    <= '0;
        end
        cur_reg   <= cur_next;
        start_reg <= start_next;
        len_reg   <= len_next;
        if (ctl.search_step && !need_read && page_free
            && len_reg + PCNT_W'(1) >= count_reg)
        begin
            tcur_reg <= (TABLE_W+1)'((len_reg == '0 ? cur_reg : start_reg) / PAGES_PER_TABLE);
        end
        else if (ctl.create_step)
            tcur_reg <= tcur_reg + (TABLE_W+1)'(1);
        if (ctl.create_step && present_next != present_reg)
            made_reg <= made_reg + MADE_W'(1);
        if (ctl.load)
            end_reg <= first_ext + cnt_ext - PCNT_W'(1);
        else if (ctl.create_step)
            end_reg <= end_calc;
        if (ctl.finish)
        begin
            if (trivial_reg)
                status_reg <= (count_reg == '0) ? ST_OK : ST_RANGE;
            else if (cmd_reg == CMD_ALLOC && !found_reg)
                status_reg <= ST_NO_SPACE;
            else
                status_reg <= ST_OK;
            first_reg <= (cmd_reg == CMD_ALLOC && found_reg && !trivial_reg)
                         ? FIRST_W'(start_reg) : '0;
            tc_reg    <= (cmd_reg == CMD_ALLOC && found_reg && !trivial_reg)
                         ? made_reg : '0;
        end
    end

    // memory port: zero after reset, read on refill, read-modify-write on mark.
    // Marks of an absent table stay clear, so a new table needs no clearing.
    always_ff @(posedge clk)
    begin
        if (ctl.clear_step)
            mem[clr_reg] <= '0;
        else if ((ctl.search_step || ctl.mark_step) && need_read)
        begin
            word_reg      <= mem[cur_widx];
            word_addr_reg <= cur_widx;
        end
        else if (ctl.mark_step)
        begin
            word_reg[cur_bit] <= (cmd_reg == CMD_ALLOC);
            mem[cur_widx]     <= page_word(word_reg, cur_bit, cmd_reg == CMD_ALLOC);
        end
    end

    assign sts.clear_end  = clr_reg == WIDX_W'(WORD_COUNT - 1);
    assign sts.found      = found_reg;
    assign sts.search_end = ctl.search_step && !need_read && cur_reg == PCNT_W'(TOTAL_PAGES - 1)
                            && !(page_free && len_reg + PCNT_W'(1) >= count_reg);
    assign sts.create_end = tcur_reg >= (TABLE_W+1)'(end_calc / PAGES_PER_TABLE)
                            || tcur_reg == (TABLE_W+1)'(TABLE_COUNT - 1);
    assign sts.mark_end   = !need_read && cur_reg == end_reg;
    assign sts.trivial    = trivial_reg;
    assign sts.cmd        = cmd_reg;

    assign status            = status_reg;
    assign first_page_out    = first_reg;
    assign tables_created    = tc_reg;
    assign directory_version = version_reg;

endmodule

>>> rtl/core/contiguous_page_run_allocator_core.sv
// Channel   | handshake           | payload
// request   | start / busy        | command, page_count, first_page_in
// result    | strobe (no stall)   | status, first_page_out, tables_created, directory_version
// After reset a clearing pass zeroes the page marks, one 32-page word per cycle,
// with busy held high. An allocate tests one page per cycle from page 1, pausing for
// a read at each new 32-page word, until a run is found or the last page is tested;
// then the tables the run spans are created and its pages are marked, with a read at
// each new word. A free clears the marks of its pages, with a read at each new word;
// zero-count requests and range faults skip the work and go from the search state
// straight to the done state. The strobe is registered from the done state and rises
// in the cycle after it; the receiver cannot stall.
// Depends on cpra_pkg, cpra_ctrl, cpra_dp.
module contiguous_page_run_allocator_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic [cpra_pkg::COUNT_W-1:0]       page_count,
    input  logic [cpra_pkg::FIRST_W-1:0]       first_page_in,
    output logic                               strobe,
    output logic [cpra_pkg::STATUS_W-1:0]      status,
    output logic [cpra_pkg::FIRST_W-1:0]       first_page_out,
    output logic [cpra_pkg::MADE_W-1:0]        tables_created,
    output logic [cpra_pkg::VERSION_W-1:0]     directory_version
);
    import cpra_pkg::*;

    ctl_t ctl;
    sts_t sts;
    logic done;
    logic strobe_reg;

    cpra_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .sts    (sts),
        .ctl    (ctl),
        .busy   (busy),
        .strobe (done)
    );

    cpra_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .command           (command),
        .page_count        (page_count),
        .first_page_in     (first_page_in),
        .sts               (sts),
        .status            (status),
        .first_page_out    (first_page_out),
        .tables_created    (tables_created),
        .directory_version (directory_version)
    );

    // results land in the cycle after the finish step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= done;
    end

    assign strobe = strobe_reg;

endmodule

>>> rtl/core/cpra_checker.sv
// Port-level checker for the page-run allocator, bound to the top level.
// Depends on cpra_pkg.
module cpra_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           strobe,
    input logic [cpra_pkg::STATUS_W-1:0]  status,
    input logic [cpra_pkg::FIRST_W-1:0]   first_page_out,
    input logic [cpra_pkg::MADE_W-1:0]    tables_created,
    input logic [cpra_pkg::VERSION_W-1:0] directory_version
);
    import cpra_pkg::*;

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("request not taken");

    a_no_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy)) else $error("result with no request");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status != ST_OK |-> first_page_out == '0 && tables_created == '0)
        else $error("failed request reports a run");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> status == ST_OK || status == ST_NO_SPACE || status == ST_RANGE)
        else $error("bad status");

    a_version_steady: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> $stable(directory_version))
        else $error("version moved while idle");

endmodule

bind contiguous_page_run_allocator_core cpra_checker u_cpra_checker (.*);
